// ===== sv/mer_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_pkg
// shared command and status types between the ellipse controller and datapath
// ----------------------------------------------------------------------------
package mer_pkg;

    // operand pair fed to the shared multiplier
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_AA,     // a * a
        MUL_BB,     // b * b
        MUL_AAB,    // a^2 * b
        MUL_SQX,    // (2x+1)^2
        MUL_BBP,    // b^2 * product
        MUL_SQY,    // (y-1)^2
        MUL_AAP,    // a^2 * product
        MUL_AABB    // a^2 * b^2
    } mul_sel_t;

    // update applied to the decision accumulators
    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_INIT1,  // region one start values
        ACC_LOAD,   // decision = product, step terms moved to region two
        ACC_ADD4,   // decision += 4 * product
        ACC_SUB4    // decision -= 4 * product
    } acc_sel_t;

    // point emitted this cycle
    typedef enum logic [1:0] {
        STEP_NONE,
        STEP_START,
        STEP_R1,
        STEP_R2
    } step_t;

    typedef struct packed {
        logic     load;
        logic     ld_aa;
        logic     ld_bb;
        mul_sel_t mul;
        acc_sel_t acc;
        step_t    step;
    } mer_cmd_t;

    typedef struct packed {
        logic out_free;
        logic r1_go;
        logic emit_last;
    } mer_status_t;

endpackage

// ===== sv/midpoint_ellipse_rasterizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_ellipse_rasterizer
// first-quadrant midpoint ellipse point generator
// ----------------------------------------------------------------------------
// s_axis carries one command word, semi-axes a and b of an axis-aligned
// ellipse. m_axis returns the raster points from (0,b) to (x,0), one word per
// point, in_region_two on tuser and the final point flagged by tlast. a new
// command is taken only after the previous run has loaded its last point
// into the output register.
// the first point follows three setup multiplies (a*a, b*b, a^2*b) and an
// init step. each region then yields one point per cycle while the
// receiver keeps up; between the regions come the region exit test and the
// region two setup multiplies. region two is skipped when region one ends
// at y=0.
// rst_n clears the controller to idle and drops m_axis_tvalid. while
// m_axis_tready is low the held word stays put and the step loop waits
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer
    import mer_pkg::*;
#(
    parameter int AXIS_BITS = 5
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // semi_axis_x, semi_axis_y
    input  logic [((2*AXIS_BITS+7)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // point_x, point_y
    output logic [((2*AXIS_BITS+7)/8)*8-1:0]     m_axis_tdata,
    // in_region_two
    output logic [0:0]                           m_axis_tuser,
    output logic                                 m_axis_tlast
);

    localparam int DATA_W = ((2 * AXIS_BITS + 7) / 8) * 8;

    mer_cmd_t             cmd;
    mer_status_t          status;
    logic [AXIS_BITS-1:0] point_x;
    logic [AXIS_BITS-1:0] point_y;
    logic                 in_region_two;

    mer_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mer_datapath #(
        .AXIS_BITS (AXIS_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .semi_axis_x   (s_axis_tdata[AXIS_BITS-1:0]),
        .semi_axis_y   (s_axis_tdata[2*AXIS_BITS-1:AXIS_BITS]),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .point_x       (point_x),
        .point_y       (point_y),
        .in_region_two (in_region_two),
        .last_point    (m_axis_tlast)
    );

    assign m_axis_tdata = DATA_W'({point_y, point_x});
    assign m_axis_tuser = in_region_two;

endmodule

// ===== sv/mer_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_ctrl
// sequencer for setup multiplies, region one walk, region two setup and walk
// ----------------------------------------------------------------------------
module mer_ctrl
    import mer_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  mer_status_t status,
    output mer_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_AA,
        ST_MUL_BB,
        ST_MUL_AAB,
        ST_INIT,
        ST_START,
        ST_R1,
        ST_R2_SQX,
        ST_R2_BBP,
        ST_R2_LOAD,
        ST_R2_AAP,
        ST_R2_ADD,
        ST_R2_SUB,
        ST_R2
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL_AA;
                end
            end
            ST_MUL_AA:
            begin
                cmd.mul    = MUL_AA;
                state_next = ST_MUL_BB;
            end
            ST_MUL_BB:
            begin
                cmd.mul    = MUL_BB;
                cmd.ld_aa  = 1'b1;
                state_next = ST_MUL_AAB;
            end
            ST_MUL_AAB:
            begin
                cmd.mul    = MUL_AAB;
                cmd.ld_bb  = 1'b1;
                state_next = ST_INIT;
            end
            ST_INIT:
            begin
                cmd.acc    = ACC_INIT1;
                state_next = ST_START;
            end
            ST_START:
            begin
                if (status.out_free)
                begin
                    cmd.step   = STEP_START;
                    state_next = status.emit_last ? ST_IDLE : ST_R1;
                end
            end
            ST_R1:
            begin
                if (status.r1_go)
                begin
                    if (status.out_free)
                    begin
                        cmd.step = STEP_R1;
                        if (status.emit_last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else
                begin
                    state_next = ST_R2_SQX;
                end
            end
            ST_R2_SQX:
            begin
                cmd.mul    = MUL_SQX;
                state_next = ST_R2_BBP;
            end
            ST_R2_BBP:
            begin
                cmd.mul    = MUL_BBP;
                state_next = ST_R2_LOAD;
            end
            ST_R2_LOAD:
            begin
                cmd.acc    = ACC_LOAD;
                cmd.mul    = MUL_SQY;
                state_next = ST_R2_AAP;
            end
            ST_R2_AAP:
            begin
                cmd.mul    = MUL_AAP;
                state_next = ST_R2_ADD;
            end
            ST_R2_ADD:
            begin
                cmd.acc    = ACC_ADD4;
                cmd.mul    = MUL_AABB;
                state_next = ST_R2_SUB;
            end
            ST_R2_SUB:
            begin
                cmd.acc    = ACC_SUB4;
                state_next = ST_R2;
            end
            ST_R2:
            begin
                if (status.out_free)
                begin
                    cmd.step = STEP_R2;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sv/mer_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mer_datapath
// shared multiplier, decision accumulators, point counters and output word
// ----------------------------------------------------------------------------
module mer_datapath
    import mer_pkg::*;
#(
    parameter int AXIS_BITS = 5
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  mer_cmd_t             cmd,
    output mer_status_t          status,
    input  logic [AXIS_BITS-1:0] semi_axis_x,
    input  logic [AXIS_BITS-1:0] semi_axis_y,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [AXIS_BITS-1:0] point_x,
    output logic [AXIS_BITS-1:0] point_y,
    output logic                 in_region_two,
    output logic                 last_point
);

    localparam int SQ_W  = 2 * AXIS_BITS;
    localparam int MUL_W = 2 * AXIS_BITS + 2;
    localparam int PRD_W = 2 * MUL_W;
    localparam int DEC_W = 4 * AXIS_BITS + 8;
    localparam int CNT_W = AXIS_BITS + 1;
    localparam logic [CNT_W-1:0] MAX_PTS = CNT_W'(2 * (2 ** AXIS_BITS - 1) + 1);

    logic [AXIS_BITS-1:0]    a_reg;
    logic [AXIS_BITS-1:0]    x_reg;
    logic [AXIS_BITS-1:0]    y_reg;
    logic [SQ_W-1:0]         aa_reg;
    logic [SQ_W-1:0]         bb_reg;
    logic [PRD_W-1:0]        prod_reg;
    logic signed [DEC_W-1:0] dec_reg;
    logic signed [DEC_W-1:0] l_reg;     // a^2 (2y-1)
    logic signed [DEC_W-1:0] r_reg;     // 2 b^2 (x+1)
    logic signed [DEC_W-1:0] t_reg;     // x step term
    logic signed [DEC_W-1:0] u_reg;     // y step term
    logic [CNT_W-1:0]        n_reg;

    logic                    out_valid_reg;
    logic [AXIS_BITS-1:0]    out_x_reg;
    logic [AXIS_BITS-1:0]    out_y_reg;
    logic                    out_r2_reg;
    logic                    out_last_reg;

    logic [MUL_W-1:0]        mul_a;
    logic [MUL_W-1:0]        mul_b;
    logic signed [DEC_W-1:0] aa_w;
    logic signed [DEC_W-1:0] bb_w;
    logic signed [DEC_W-1:0] prod_w;
    logic                    dec_neg;
    logic [AXIS_BITS-1:0]    y_dec;
    logic [AXIS_BITS-1:0]    y_r1;
    logic                    cap_next;
    logic                    emit;
    logic                    emit_last;
    logic [AXIS_BITS-1:0]    emit_x;
    logic [AXIS_BITS-1:0]    emit_y;

    assign aa_w    = DEC_W'(aa_reg);
    assign bb_w    = DEC_W'(bb_reg);
    assign prod_w  = DEC_W'(prod_reg);
    assign dec_neg = dec_reg[DEC_W-1];
    assign y_dec   = y_reg - AXIS_BITS'(1);
    assign y_r1    = dec_neg ? y_reg : y_dec;
    assign cap_next = (n_reg == MAX_PTS - CNT_W'(1));
    assign emit    = (cmd.step != STEP_NONE);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul)
            MUL_AA:
            begin
                mul_a = MUL_W'(a_reg);
                mul_b = MUL_W'(a_reg);
            end
            MUL_BB:
            begin
                mul_a = MUL_W'(y_reg);
                mul_b = MUL_W'(y_reg);
            end
            MUL_AAB:
            begin
                mul_a = MUL_W'(aa_reg);
                mul_b = MUL_W'(y_reg);
            end
            MUL_SQX:
            begin
                mul_a = MUL_W'({x_reg, 1'b1});
                mul_b = MUL_W'({x_reg, 1'b1});
            end
            MUL_BBP:
            begin
                mul_a = MUL_W'(bb_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            MUL_SQY:
            begin
                mul_a = MUL_W'(y_dec);
                mul_b = MUL_W'(y_dec);
            end
            MUL_AAP:
            begin
                mul_a = MUL_W'(aa_reg);
                mul_b = prod_reg[MUL_W-1:0];
            end
            MUL_AABB:
            begin
                mul_a = MUL_W'(aa_reg);
                mul_b = MUL_W'(bb_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        emit_x    = x_reg;
        emit_y    = y_reg;
        emit_last = 1'b0;
        case (cmd.step)
            STEP_START:
            begin
                emit_x    = x_reg;
                emit_y    = y_reg;
                emit_last = (y_reg == '0) || cap_next;
            end
            STEP_R1:
            begin
                emit_x    = x_reg + AXIS_BITS'(1);
                emit_y    = y_r1;
                emit_last = (y_r1 == '0) || cap_next;
            end
            STEP_R2:
            begin
                emit_x    = dec_neg ? x_reg + AXIS_BITS'(1) : x_reg;
                emit_y    = y_dec;
                emit_last = (y_dec == '0) || cap_next;
            end
            default:
            begin
                emit_last = 1'b0;
            end
        endcase
    end

    assign status.emit_last = emit_last;
    assign status.out_free  = !out_valid_reg || out_ready;
    assign status.r1_go     = (l_reg > r_reg) && (n_reg != MAX_PTS);

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            a_reg <= semi_axis_x;
            x_reg <= '0;
            y_reg <= semi_axis_y;
        end
        else if (cmd.step == STEP_R1)
        begin
            x_reg <= x_reg + AXIS_BITS'(1);
            y_reg <= y_r1;
        end
        else if (cmd.step == STEP_R2)
        begin
            x_reg <= emit_x;
            y_reg <= y_dec;
        end

        if (cmd.mul != MUL_NONE)
        begin
            prod_reg <= PRD_W'(mul_a) * PRD_W'(mul_b);
        end
        if (cmd.ld_aa)
        begin
            aa_reg <= prod_reg[SQ_W-1:0];
        end
        if (cmd.ld_bb)
        begin
            bb_reg <= prod_reg[SQ_W-1:0];
        end

        case (cmd.acc)
            ACC_INIT1:
            begin
                dec_reg <= (bb_w <<< 2) - (prod_w <<< 2) + aa_w;
                l_reg   <= (prod_w <<< 1) - aa_w;
                r_reg   <= bb_w <<< 1;
                t_reg   <= (bb_w <<< 3) + (bb_w <<< 2);
                u_reg   <= (aa_w <<< 3) - (prod_w <<< 3);
            end
            ACC_LOAD:
            begin
                // region two uses 4b^2(2x+2) and 4a^2(3-2y)
                dec_reg <= prod_w;
                t_reg   <= t_reg - (bb_w <<< 2);
                u_reg   <= u_reg + (aa_w <<< 2);
            end
            ACC_ADD4:
            begin
                dec_reg <= dec_reg + (prod_w <<< 2);
            end
            ACC_SUB4:
            begin
                dec_reg <= dec_reg - (prod_w <<< 2);
            end
            default:
            begin
                case (cmd.step)
                    STEP_R1:
                    begin
                        r_reg <= r_reg + (bb_w <<< 1);
                        t_reg <= t_reg + (bb_w <<< 3);
                        if (dec_neg)
                        begin
                            dec_reg <= dec_reg + t_reg;
                        end
                        else
                        begin
                            dec_reg <= dec_reg + t_reg + u_reg;
                            l_reg   <= l_reg - (aa_w <<< 1);
                            u_reg   <= u_reg + (aa_w <<< 3);
                        end
                    end
                    STEP_R2:
                    begin
                        u_reg <= u_reg + (aa_w <<< 3);
                        if (dec_neg)
                        begin
                            dec_reg <= dec_reg + t_reg + u_reg;
                            t_reg   <= t_reg + (bb_w <<< 3);
                        end
                        else
                        begin
                            dec_reg <= dec_reg + u_reg;
                        end
                    end
                    default:
                    begin
                        dec_reg <= dec_reg;
                    end
                endcase
            end
        endcase

        if (emit)
        begin
            out_x_reg    <= emit_x;
            out_y_reg    <= emit_y;
            out_r2_reg   <= (cmd.step == STEP_R2);
            out_last_reg <= emit_last;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                n_reg <= '0;
            end
            else if (emit)
            begin
                n_reg <= n_reg + CNT_W'(1);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign point_x       = out_x_reg;
    assign point_y       = out_y_reg;
    assign in_region_two = out_r2_reg;
    assign last_point    = out_last_reg;

endmodule
